// ===== hdl/rcp_pkg.sv =====
`default_nettype none
package rcp_pkg;
  localparam int CoordBits  = 16;
  localparam int FracBits   = 8;
  localparam int OutBits    = CoordBits + FracBits;
  localparam int RadiusBits = 23;
  // S*ONE*ONE fits in 2*(CoordBits+1)+2*FracBits bits
  localparam int SqBits     = 2 * (CoordBits + 1) + 2 * FracBits;
  localparam int RootBits   = SqBits / 2;
  localparam int DiffBits   = CoordBits + 1;
  // numerator mag*dist*ONE*2 + len
  localparam int NumBits    = CoordBits + RadiusBits + FracBits + 2;
  localparam logic [RadiusBits-1:0] RadiusReset = RadiusBits'(12800);

  typedef enum logic [1:0] {
    CMD_MOVE = 2'd0,
    CMD_LINE = 2'd1,
    CMD_QUAD = 2'd2
  } path_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT_A,
    ST_SQRT_B,
    ST_DIV_AX,
    ST_DIV_AY,
    ST_DIV_BX,
    ST_DIV_BY,
    ST_EMIT_LINE,
    ST_EMIT_QUAD,
    ST_EMIT_LAST,
    ST_EMIT_FIRST,
    ST_EMIT_SECOND
  } rcp_state_t;

  typedef struct packed {
    logic load;       // capture input vertex and differences
    logic sqrt_start; // start root of edge selected by sel_b
    logic div_start;  // start divide, component selected by div_sel
    logic sel_b;
    logic [1:0] div_sel;
  } rcp_cmd_t;

  typedef struct packed {
    logic busy;
  } rcp_stat_t;
endpackage
`default_nettype wire

// ===== hdl/rcp_ctrl.sv =====
`default_nettype none
module rcp_ctrl
  import rcp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_final,
  output logic            out_valid,
  input  wire logic       out_ready,
  output path_cmd_t       out_cmd,
  output logic [1:0]      out_sel,   // 0 newest vertex/end, 1 pull a, 2 pull b
  output logic            out_last,
  output rcp_cmd_t        cmd,
  input  rcp_stat_t       stat
);
  rcp_state_t state_r, state_nxt;
  logic [1:0] held_r, held_nxt;
  logic fin_r, fin_nxt;
  // step units are busy from the cycle after start; busy is sampled after that
  logic started_r, started_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_r  <= 2'd0;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    fin_nxt   = fin_r;
    case (state_r)
      ST_IDLE: if (in_valid) begin
        fin_nxt = in_final;
        case (held_r)
          2'd0: state_nxt = ST_EMIT_FIRST;
          2'd1: begin
            held_nxt  = in_final ? 2'd0 : 2'd2;
            state_nxt = in_final ? ST_EMIT_SECOND : ST_IDLE;
          end
          default: state_nxt = ST_SQRT_A;
        endcase
      end
      ST_SQRT_A: if (started_r && !stat.busy) state_nxt = ST_SQRT_B;
      ST_SQRT_B: if (started_r && !stat.busy) state_nxt = ST_DIV_AX;
      ST_DIV_AX: if (started_r && !stat.busy) state_nxt = ST_DIV_AY;
      ST_DIV_AY: if (started_r && !stat.busy) state_nxt = ST_DIV_BX;
      ST_DIV_BX: if (started_r && !stat.busy) state_nxt = ST_DIV_BY;
      ST_DIV_BY: if (started_r && !stat.busy) state_nxt = ST_EMIT_LINE;
      ST_EMIT_LINE: if (out_ready) state_nxt = ST_EMIT_QUAD;
      ST_EMIT_QUAD: if (out_ready) begin
        state_nxt = fin_r ? ST_EMIT_LAST : ST_IDLE;
        if (fin_r) held_nxt = 2'd0;
      end
      ST_EMIT_LAST: if (out_ready) state_nxt = ST_IDLE;
      ST_EMIT_FIRST: if (out_ready) begin
        state_nxt = ST_IDLE;
        held_nxt  = fin_r ? 2'd0 : 2'd1;
      end
      ST_EMIT_SECOND: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) started_r <= 1'b0;
    else        started_r <= started_nxt;
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = 1'b0;
    out_cmd   = CMD_LINE;
    out_sel   = 2'd0;
    out_last  = 1'b0;
    cmd       = '0;
    started_nxt = 1'b0;
    cmd.load  = (state_r == ST_IDLE) && in_valid;
    case (state_r)
      ST_SQRT_A, ST_SQRT_B, ST_DIV_AX, ST_DIV_AY, ST_DIV_BX, ST_DIV_BY: begin
        started_nxt = 1'b1;
        if (!started_r) begin
          cmd.sqrt_start = (state_r == ST_SQRT_A) || (state_r == ST_SQRT_B);
          cmd.div_start  = !cmd.sqrt_start;
        end
        if (started_r && !stat.busy) started_nxt = 1'b0;
      end
      default: ;
    endcase
    cmd.sel_b = (state_r == ST_SQRT_B);
    case (state_r)
      ST_DIV_AY: cmd.div_sel = 2'd1;
      ST_DIV_BX: cmd.div_sel = 2'd2;
      ST_DIV_BY: cmd.div_sel = 2'd3;
      default:   cmd.div_sel = 2'd0;
    endcase
    case (state_r)
      ST_EMIT_LINE: begin out_valid = 1'b1; out_sel = 2'd1; end
      ST_EMIT_QUAD: begin
        out_valid = 1'b1; out_cmd = CMD_QUAD; out_sel = 2'd2; out_last = !fin_r;
      end
      ST_EMIT_LAST: begin out_valid = 1'b1; out_last = 1'b1; end
      ST_EMIT_FIRST: begin out_valid = 1'b1; out_cmd = CMD_MOVE; out_last = 1'b1; end
      ST_EMIT_SECOND: begin out_valid = 1'b1; out_last = 1'b1; end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/rcp_dp.sv =====
`default_nettype none
module rcp_dp
  import rcp_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic signed [CoordBits-1:0]  in_x,
  input  wire logic signed [CoordBits-1:0]  in_y,
  input  wire logic [RadiusBits-1:0]        radius,
  input  rcp_cmd_t                          cmd,
  output rcp_stat_t                         stat,
  input  wire logic [1:0]                   out_sel,
  input  wire logic                         out_quad,
  output logic signed [OutBits-1:0]         end_x,
  output logic signed [OutBits-1:0]         end_y,
  output logic signed [OutBits-1:0]         ctrl_x,
  output logic signed [OutBits-1:0]         ctrl_y
);
  logic signed [CoordBits-1:0] px_r, py_r;
  logic signed [DiffBits-1:0] d_r [4];   // ax, ay, bx, by
  logic [RootBits-1:0] la_r, lb_r;
  logic signed [OutBits+1:0] off_r [4];

  // px/py hold the newest vertex, cx/cy the one before it (the corner)
  logic signed [CoordBits-1:0] cx_r, cy_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r  <= in_x;
      py_r  <= in_y;
      cx_r  <= px_r;  cy_r  <= py_r;
      d_r[0] <= DiffBits'(cx_r) - DiffBits'(px_r);
      d_r[1] <= DiffBits'(cy_r) - DiffBits'(py_r);
      d_r[2] <= DiffBits'(in_x) - DiffBits'(px_r);
      d_r[3] <= DiffBits'(in_y) - DiffBits'(py_r);
    end
  end

  // square root, two radicand bits per step
  logic [SqBits-1:0] sq_x_r;
  logic [$clog2(RootBits+1)-1:0] sq_cnt_r;
  logic sq_busy_r, sq_b_r;
  logic [DiffBits-2:0] mx, my;
  logic [2*DiffBits-1:0] sx, sy;
  logic [SqBits-1:0] s_full;
  logic signed [DiffBits-1:0] ex, ey;

  always_comb begin
    ex = cmd.sel_b ? d_r[2] : d_r[0];
    ey = cmd.sel_b ? d_r[3] : d_r[1];
    mx = ex[DiffBits-1] ? (DiffBits-1)'(-ex) : ex[DiffBits-2:0];
    my = ey[DiffBits-1] ? (DiffBits-1)'(-ey) : ey[DiffBits-2:0];
    sx = (2*DiffBits)'(mx) * (2*DiffBits)'(mx);
    sy = (2*DiffBits)'(my) * (2*DiffBits)'(my);
    s_full = (SqBits'(sx) + SqBits'(sy)) << (2 * FracBits);
  end

  // restoring root: remainder rem, root q
  logic [RootBits+1:0] rem_r;
  logic [RootBits-1:0] q_r;
  logic [RootBits+1:0] trial;
  logic [RootBits+1:0] rem_next;
  always_comb begin
    rem_next = {rem_r[RootBits-1:0], sq_x_r[SqBits-1 -: 2]};
    trial    = {q_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else begin
      if (cmd.sqrt_start) begin
        sq_busy_r <= 1'b1;
        sq_x_r    <= s_full;
        rem_r     <= '0;
        q_r       <= '0;
        sq_cnt_r  <= '0;
        sq_b_r    <= cmd.sel_b;
      end else if (sq_busy_r &&
                   sq_cnt_r != ($clog2(RootBits+1))'(RootBits)) begin
        sq_x_r   <= sq_x_r << 2;
        sq_cnt_r <= sq_cnt_r + 1'b1;
        if (rem_next >= trial) begin
          rem_r <= rem_next - trial;
          q_r   <= {q_r[RootBits-2:0], 1'b1};
        end else begin
          rem_r <= rem_next;
          q_r   <= {q_r[RootBits-2:0], 1'b0};
        end
      end else if (sq_busy_r) begin
        // round to nearest: remainder n - q*q > q means add one
        if (RootBits'(rem_r) > q_r || rem_r[RootBits+1:RootBits] != 2'b00) begin
          if (sq_b_r) lb_r <= q_r + 1'b1; else la_r <= q_r + 1'b1;
        end else begin
          if (sq_b_r) lb_r <= q_r; else la_r <= q_r;
        end
        sq_busy_r <= 1'b0;
      end
    end
  end

  // pull distance
  logic [RootBits-1:0] ha, hb, pull_len;
  always_comb begin
    ha = la_r >> 1;
    hb = lb_r >> 1;
    pull_len = RootBits'(radius);
    if (ha < pull_len) pull_len = ha;
    if (hb < pull_len) pull_len = hb;
  end

  // divider: (mag*dist*ONE*2 + len) / (2*len), one quotient bit per step
  logic [NumBits-1:0] dv_num_r, dv_q_r;
  logic [RootBits+1:0] dv_den_r;
  logic [RootBits+2:0] dv_rem_r;
  logic [$clog2(NumBits+1)-1:0] dv_cnt_r;
  logic dv_busy_r, dv_neg_r, dv_zero_r;
  logic [1:0] dv_sel_r;
  logic [RootBits-1:0] dv_len;
  logic signed [DiffBits-1:0] dv_d;
  logic [DiffBits-2:0] dv_mag;
  logic [NumBits-1:0] dv_prod;
  logic [RootBits+2:0] dv_sh;

  always_comb begin
    dv_d   = d_r[cmd.div_sel];
    dv_len = cmd.div_sel[1] ? lb_r : la_r;
    dv_mag = dv_d[DiffBits-1] ? (DiffBits-1)'(-dv_d) : dv_d[DiffBits-2:0];
    dv_prod = (NumBits'(dv_mag) * NumBits'(pull_len[RadiusBits-1:0])) << (FracBits + 1);
    dv_prod = dv_prod + NumBits'(dv_len);
    dv_sh   = {dv_rem_r[RootBits+1:0], dv_num_r[NumBits-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dv_busy_r <= 1'b1;
      dv_num_r  <= dv_prod;
      dv_den_r  <= {dv_len, 1'b0};
      dv_rem_r  <= '0;
      dv_q_r    <= '0;
      dv_cnt_r  <= '0;
      dv_neg_r  <= dv_d[DiffBits-1];
      dv_zero_r <= (dv_len == '0);
      dv_sel_r  <= cmd.div_sel;
    end else if (dv_busy_r) begin
      if (dv_cnt_r != ($clog2(NumBits+1))'(NumBits)) begin
        dv_cnt_r <= dv_cnt_r + 1'b1;
        dv_num_r <= dv_num_r << 1;
        if (dv_sh >= (RootBits+3)'(dv_den_r)) begin
          dv_rem_r <= dv_sh - (RootBits+3)'(dv_den_r);
          dv_q_r   <= {dv_q_r[NumBits-2:0], 1'b1};
        end else begin
          dv_rem_r <= dv_sh;
          dv_q_r   <= {dv_q_r[NumBits-2:0], 1'b0};
        end
      end else begin
        dv_busy_r <= 1'b0;
        if (dv_zero_r) off_r[dv_sel_r] <= '0;
        else if (dv_neg_r) off_r[dv_sel_r] <= -(OutBits+2)'(dv_q_r);
        else off_r[dv_sel_r] <= (OutBits+2)'(dv_q_r);
      end
    end
  end

  assign stat.busy = sq_busy_r || dv_busy_r;

  function automatic logic signed [OutBits-1:0] sat(input logic signed [OutBits+2:0] v);
    logic signed [OutBits+2:0] hi, lo;
    hi = (OutBits+3)'((1 << (OutBits-1)) - 1);
    lo = -hi - 1;
    if (v > hi) return hi[OutBits-1:0];
    if (v < lo) return lo[OutBits-1:0];
    return v[OutBits-1:0];
  endfunction

  logic signed [OutBits+2:0] qcx, qcy, qpx, qpy;
  always_comb begin
    qcx = (OutBits+3)'(cx_r) <<< FracBits;
    qcy = (OutBits+3)'(cy_r) <<< FracBits;
    qpx = (OutBits+3)'(px_r) <<< FracBits;
    qpy = (OutBits+3)'(py_r) <<< FracBits;
    case (out_sel)
      2'd1: begin
        end_x = sat(qcx + (OutBits+3)'(off_r[0]));
        end_y = sat(qcy + (OutBits+3)'(off_r[1]));
      end
      2'd2: begin
        end_x = sat(qcx + (OutBits+3)'(off_r[2]));
        end_y = sat(qcy + (OutBits+3)'(off_r[3]));
      end
      default: begin
        end_x = sat(qpx);
        end_y = sat(qpy);
      end
    endcase
    ctrl_x = out_quad ? sat(qcx) : '0;
    ctrl_y = out_quad ? sat(qcy) : '0;
  end
endmodule
`default_nettype wire

// ===== hdl/rounded_corner_polyline_unit.sv =====
// Rounded-corner polyline path generator.
// Input channel in_*: one vertex per beat (in_point_x/y integer pixels,
// in_final_point marks the polyline's last vertex).
// Output channel out_*: path commands; move-to for the first vertex,
// line-to plus quadratic curve-to for each corner, line-to for the end.
// out_run_last flags the last command caused by a vertex.
// Config channel cfg_*: corner radius, unsigned Q15.8; always ready, write
// it only while no vertex is in flight.
// A corner vertex runs two square roots (one root bit per cycle) and four
// divides (one quotient bit per cycle) in turn through shared step units;
// the line-to is presented once the last divide is done.
// The controller holds each command on the outputs until out_ready;
// while the receiver stalls no further vertex is taken.
// Reset clears the held-vertex count and sets the radius to 50.0 pixels.
`default_nettype none
module rounded_corner_polyline_unit
  import rcp_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [CoordBits-1:0] in_point_x,
  input  wire logic signed [CoordBits-1:0] in_point_y,
  input  wire logic                        in_final_point,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_path_cmd,
  output logic signed [OutBits-1:0]        out_end_x,
  output logic signed [OutBits-1:0]        out_end_y,
  output logic signed [OutBits-1:0]        out_ctrl_x,
  output logic signed [OutBits-1:0]        out_ctrl_y,
  output logic                             out_run_last,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [RadiusBits-1:0]       cfg_corner_radius
);
  logic [RadiusBits-1:0] radius_r;
  rcp_cmd_t  cmd;
  rcp_stat_t stat;
  path_cmd_t pc;
  logic [1:0] sel;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) radius_r <= RadiusReset;
    else if (cfg_valid) radius_r <= cfg_corner_radius;
  end

  rcp_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_final(in_final_point),
    .out_valid, .out_ready, .out_cmd(pc), .out_sel(sel),
    .out_last(out_run_last), .cmd, .stat
  );

  rcp_dp u_dp (
    .clk, .rst_n, .in_x(in_point_x), .in_y(in_point_y), .radius(radius_r),
    .cmd, .stat, .out_sel(sel), .out_quad(pc == CMD_QUAD),
    .end_x(out_end_x), .end_y(out_end_y), .ctrl_x(out_ctrl_x), .ctrl_y(out_ctrl_y)
  );

  assign out_path_cmd = pc;
endmodule
`default_nettype wire

// ===== hdl/rcp_check.sv =====
`default_nettype none
module rcp_check
  import rcp_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] out_path_cmd,
  input wire logic signed [OutBits-1:0] out_ctrl_x,
  input wire logic signed [OutBits-1:0] out_end_x
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("vertex taken during output");
  a_ctrl_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_path_cmd != CMD_QUAD |-> out_ctrl_x == '0)
    else $error("control point not zero");
  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_path_cmd != 2'd3) else $error("bad command");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_end_x))
    else $error("output dropped");
endmodule

bind rounded_corner_polyline_unit rcp_check u_rcp_check (
  .clk, .rst_n, .in_ready, .out_valid, .out_ready,
  .out_path_cmd, .out_ctrl_x, .out_end_x
);
`default_nettype wire
